>>> design/tcgr_pkg.sv
// tcgr_pkg: shared types and constants for the text cell glyph renderer.
// Holds field widths, the 16 colour palette, item kinds and register indexes.
// No dependencies.
package tcgr_pkg;

    // Field widths of one input item
    localparam int CELL_W    = 16;
    localparam int CODE_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int SLOT_W    = 12;
    localparam int FONT_W    = 8;
    localparam int S_TDATA_W = 56;

    // Result item: row address plus eight 24-bit pixels
    localparam int ADDR_W     = 32;
    localparam int RGB_W      = 24;
    localparam int GLYPH_COLS = 8;
    localparam int M_TDATA_W  = ADDR_W + GLYPH_COLS * RGB_W;

    // Font store
    localparam int FONT_DEPTH = 1 << SLOT_W;

    // Configuration register file
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PITCH_W    = 16;
    localparam int BPP_W      = 6;
    localparam int COLS_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 2'd3;

    localparam logic [ADDR_W-1:0]  RST_FRAME_BASE = 32'd0;
    localparam logic [PITCH_W-1:0] RST_LINE_PITCH = 16'd3072;
    localparam logic [BPP_W-1:0]   RST_BPP        = 6'd24;
    localparam logic [COLS_W-1:0]  RST_COLUMNS    = 8'd128;

    // Item kinds carried in tuser
    localparam logic KIND_RENDER = 1'b0;
    localparam logic KIND_FONT   = 1'b1;

    typedef logic [RGB_W-1:0] t_rgb;

    // Standard 16 colour text palette, brown kept as AA5000
    localparam t_rgb PALETTE [0:15] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5000, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

endpackage

>>> design/text_cell_glyph_renderer.sv
// text_cell_glyph_renderer: turns one text cell into glyph rows of RGB pixels.
// Depends on tcgr_pkg for widths, palette and register indexes.
//
// Usage
//   Slave stream: tuser is the item kind (render a cell or write one font
//   byte), tdata carries the cell and font fields. A font write is stored on
//   transfer and gives no result. A render item gives GLYPH_ROWS results.
//   Master stream: one transfer per glyph row, tdata holds the row's byte
//   address and eight pixels, tlast marks the final glyph row of the cell.
//   Configuration: i_cfg_we writes register i_cfg_index with i_cfg_wdata.
// Cell flow
//   The cell index is split into column and row by a radix-2 divider that
//   retires one quotient bit a cycle; a new cell is taken when the divider
//   is idle or hands its result to stage B. The row sequencer issues one
//   font read and one result per cycle unless the output stalls, and the
//   divider meanwhile works on the next cell. Font writes are taken one per
//   cycle once earlier cells have issued all their font reads.
// Reset and stall
//   Synchronous reset clears all pipeline valids and loads register defaults;
//   the font store is not cleared. A stalled receiver freezes the output
//   register and the stages behind it; nothing is dropped or repeated.
module text_cell_glyph_renderer
    import tcgr_pkg::*;
#(
    parameter int GLYPH_ROWS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: cell_index[15:0], char_code[23:16], attribute[31:24],
    //        inverse[32], font_slot[44:33], font_bits[52:45], zero[55:53]
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind
    input  logic                  i_s_axis_tuser,
    // Master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: row_address[31:0], pixel_0[55:32], pixel_1 .. pixel_7[223:200]
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                  o_m_axis_tlast,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int ROW_W = $clog2(GLYPH_ROWS);
    localparam int CNT_W = $clog2(CELL_W);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(CELL_W - 2);

    // Divider state codes
    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_BUSY = 2'd1;
    localparam logic [1:0] A_DONE = 2'd2;

    // ---------------------------------------------------------------
    // Input field unpacking
    // ---------------------------------------------------------------
    logic [CELL_W-1:0] s_cell;
    logic [CODE_W-1:0] s_code;
    logic [ATTR_W-1:0] s_attr;
    logic              s_inv;
    logic [SLOT_W-1:0] s_slot;
    logic [FONT_W-1:0] s_bits;

    assign s_cell = i_s_axis_tdata[15:0];
    assign s_code = i_s_axis_tdata[23:16];
    assign s_attr = i_s_axis_tdata[31:24];
    assign s_inv  = i_s_axis_tdata[32];
    assign s_slot = i_s_axis_tdata[44:33];
    assign s_bits = i_s_axis_tdata[52:45];

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ADDR_W-1:0]  r_frame_base;
    logic [PITCH_W-1:0] r_line_pitch;
    logic [BPP_W-1:0]   r_bpp;
    logic [COLS_W-1:0]  r_columns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= RST_FRAME_BASE;
            r_line_pitch <= RST_LINE_PITCH;
            r_bpp        <= RST_BPP;
            r_columns    <= RST_COLUMNS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_BASE: r_frame_base <= i_cfg_wdata;
                CFG_LINE_PITCH: r_line_pitch <= i_cfg_wdata[PITCH_W-1:0];
                CFG_BPP:        r_bpp        <= i_cfg_wdata[BPP_W-1:0];
                CFG_COLUMNS:    r_columns    <= i_cfg_wdata[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline registers
    // ---------------------------------------------------------------
    // Stage A: divider
    logic [1:0]        r_a_state;
    logic [CNT_W-1:0]  r_a_cnt;
    logic [CELL_W-1:0] r_a_quo;
    logic [COLS_W-1:0] r_a_rem;
    logic [CELL_W-1:0] r_a_cell;
    logic [CODE_W-1:0] r_a_code;
    logic [ATTR_W-1:0] r_a_attr;
    logic              r_a_inv;
    // Stage B: address products and colours
    logic                     r_b_vld;
    logic [CELL_W+BPP_W-1:0]  r_b_colbpp;
    logic [ADDR_W-1:0]        r_b_linep;
    logic [CODE_W-1:0]        r_b_code;
    t_rgb                     r_b_fg;
    t_rgb                     r_b_bg;
    // Stage C: row sequencer
    logic              r_c_busy;
    logic [ROW_W-1:0]  r_c_row;
    logic [ADDR_W-1:0] r_c_addr;
    logic [SLOT_W-1:0] r_c_fbase;
    t_rgb              r_c_fg;
    t_rgb              r_c_bg;
    // Stage D: font read data
    logic              r_d_vld;
    logic [ADDR_W-1:0] r_d_addr;
    logic              r_d_last;
    t_rgb              r_d_fg;
    t_rgb              r_d_bg;
    logic [FONT_W-1:0] r_font_q;
    // Stage E: output register
    logic              r_e_vld;
    logic [ADDR_W-1:0] r_e_addr;
    logic              r_e_last;
    t_rgb              r_e_pix [GLYPH_COLS];

    logic [FONT_W-1:0] r_font_mem [FONT_DEPTH];

    // ---------------------------------------------------------------
    // Flow control, evaluated from the output back
    // ---------------------------------------------------------------
    logic e_ready, d_free, c_issue, c_last, c_free, c_load, b_free, b_load;
    logic rd_pending, s_xfer, s_render, s_font;

    assign e_ready    = !r_e_vld || i_m_axis_tready;
    assign d_free     = !r_d_vld || e_ready;
    assign c_issue    = r_c_busy && d_free;
    assign c_last     = r_c_row == LAST_ROW;
    assign c_free     = !r_c_busy || (c_issue && c_last);
    assign c_load     = r_b_vld && c_free;
    assign b_free     = !r_b_vld || c_load;
    assign b_load     = (r_a_state == A_DONE) && b_free;
    assign rd_pending = r_b_vld || r_c_busy;

    // A font write waits until every earlier cell has issued its reads
    assign o_s_axis_tready = (r_a_state == A_IDLE
                              && (i_s_axis_tuser == KIND_RENDER || !rd_pending))
                          || (b_load && i_s_axis_tuser == KIND_RENDER);
    assign s_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign s_render = s_xfer && i_s_axis_tuser == KIND_RENDER;
    assign s_font   = s_xfer && i_s_axis_tuser == KIND_FONT;

    // ---------------------------------------------------------------
    // Stage A: restoring divide, one quotient bit per cycle
    // ---------------------------------------------------------------
    logic [CELL_W-1:0] div_quo_in;
    logic [COLS_W-1:0] div_rem_in;
    logic [COLS_W:0]   div_trial;
    logic              div_ge;
    logic [CELL_W-1:0] n_a_quo;
    logic [COLS_W-1:0] n_a_rem;

    always_comb begin
        // first step runs on the incoming cell, later steps on the registers
        div_quo_in = s_render ? s_cell : r_a_quo;
        div_rem_in = s_render ? '0 : r_a_rem;
        div_trial  = {div_rem_in, div_quo_in[CELL_W-1]};
        div_ge     = div_trial >= {1'b0, r_columns};
        n_a_rem    = div_ge ? COLS_W'(div_trial - {1'b0, r_columns})
                            : div_trial[COLS_W-1:0];
        n_a_quo    = {div_quo_in[CELL_W-2:0], div_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_state <= A_IDLE;
        end else if (s_render) begin
            r_a_state <= A_BUSY;
        end else begin
            unique case (r_a_state)
                A_IDLE: ;
                A_BUSY: if (r_a_cnt == DIV_LAST) r_a_state <= A_DONE;
                A_DONE: if (b_load) r_a_state <= A_IDLE;
                default: r_a_state <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_render) begin
            r_a_cnt  <= '0;
            r_a_quo  <= n_a_quo;
            r_a_rem  <= n_a_rem;
            r_a_cell <= s_cell;
            r_a_code <= s_code;
            r_a_attr <= s_attr;
            r_a_inv  <= s_inv;
        end else if (r_a_state == A_BUSY) begin
            r_a_cnt <= r_a_cnt + 1'b1;
            r_a_quo <= n_a_quo;
            r_a_rem <= n_a_rem;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: column offset, line offset and colours
    // ---------------------------------------------------------------
    logic [CELL_W-1:0] a_col;
    logic [CELL_W-1:0] a_row;
    logic [ADDR_W-1:0] a_line;
    t_rgb              a_fg;
    t_rgb              a_bg;

    always_comb begin
        // zero columns puts every cell on the first text row
        if (r_columns == '0) begin
            a_col = r_a_cell;
            a_row = '0;
        end else begin
            a_col = {{(CELL_W-COLS_W){1'b0}}, r_a_rem};
            a_row = r_a_quo;
        end
        a_line = ADDR_W'(ADDR_W'(a_row) * ADDR_W'(GLYPH_ROWS));
        a_fg   = PALETTE[r_a_attr[3:0]];
        a_bg   = PALETTE[{1'b0, r_a_attr[6:4]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_load) begin
            r_b_vld <= 1'b1;
        end else if (c_load) begin
            r_b_vld <= 1'b0;
        end
    end

    // eight pixels of bpp bits make bpp bytes per cell column
    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_colbpp <= (CELL_W+BPP_W)'(a_col * r_bpp);
            r_b_linep  <= ADDR_W'(a_line * {{(ADDR_W-PITCH_W){1'b0}}, r_line_pitch});
            r_b_code   <= r_a_code;
            r_b_fg     <= r_a_inv ? a_bg : a_fg;
            r_b_bg     <= r_a_inv ? a_fg : a_bg;
        end
    end

    // ---------------------------------------------------------------
    // Stage C: unless the output stalls, one glyph row per cycle
    // ---------------------------------------------------------------
    logic [SLOT_W-1:0] c_faddr;
    assign c_faddr = r_c_fbase + SLOT_W'(r_c_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_busy <= 1'b0;
        end else if (c_load) begin
            r_c_busy <= 1'b1;
        end else if (c_issue && c_last) begin
            r_c_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_c_row   <= '0;
            r_c_addr  <= r_frame_base + ADDR_W'(r_b_colbpp) + r_b_linep;
            r_c_fbase <= SLOT_W'(r_b_code * GLYPH_ROWS);
            r_c_fg    <= r_b_fg;
            r_c_bg    <= r_b_bg;
        end else if (c_issue) begin
            r_c_row  <= r_c_row + 1'b1;
            r_c_addr <= r_c_addr + ADDR_W'(r_line_pitch);
        end
    end

    // ---------------------------------------------------------------
    // Font store: write on font transfer, registered read on issue
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_font) begin
            r_font_mem[s_slot] <= s_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_issue) begin
            r_font_q <= r_font_mem[c_faddr];
        end
    end

    // ---------------------------------------------------------------
    // Stage D: carries row data beside the font byte
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (d_free) begin
            r_d_vld <= c_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_issue) begin
            r_d_addr <= r_c_addr;
            r_d_last <= c_last;
            r_d_fg   <= r_c_fg;
            r_d_bg   <= r_c_bg;
        end
    end

    // ---------------------------------------------------------------
    // Stage E: pixel expansion into the output register
    // ---------------------------------------------------------------
    t_rgb n_e_pix [GLYPH_COLS];

    always_comb begin
        // bit 7 is the leftmost pixel
        for (int p = 0; p < GLYPH_COLS; p++) begin
            n_e_pix[p] = r_font_q[GLYPH_COLS-1-p] ? r_d_fg : r_d_bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (e_ready) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d_vld && e_ready) begin
            r_e_addr <= r_d_addr;
            r_e_last <= r_d_last;
            r_e_pix  <= n_e_pix;
        end
    end

    // Output packing
    always_comb begin
        o_m_axis_tdata[ADDR_W-1:0] = r_e_addr;
        for (int p = 0; p < GLYPH_COLS; p++) begin
            o_m_axis_tdata[ADDR_W + p*RGB_W +: RGB_W] = r_e_pix[p];
        end
    end

    assign o_m_axis_tvalid = r_e_vld;
    assign o_m_axis_tlast  = r_e_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A font write never overtakes reads of an earlier cell
    a_font_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_font |-> (r_a_state == A_IDLE && !r_b_vld && !r_c_busy))
        else $error("font write accepted with reads outstanding");

    // A finished quotient stays put until stage B takes it
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_state == A_DONE && !b_load) |=>
            (r_a_state == A_DONE && $stable(r_a_quo) && $stable(r_a_rem)))
        else $error("divider result lost before hand-off");

    // Row counter stays inside the glyph
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_busy |-> r_c_row <= LAST_ROW)
        else $error("row sequencer ran past the last glyph row");

    // Font read data holds while stage D is stalled
    a_font_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_vld && !e_ready) |=> (r_d_vld && $stable(r_font_q)))
        else $error("font byte changed under a stall");

endmodule
